// ===== src/sgm_pkg.sv =====
`timescale 1ns / 1ps
// sgm_pkg: shared types and constants of the sobel gradient magnitude block
// no dependencies

package sgm_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_W        = 12;
    localparam int ROW_W        = 12;
    localparam int SUM_W        = 11;
    localparam int MAG_W        = 12;
    localparam int MAG_MAX      = (1 << MAG_W) - 1;

    localparam int MIN_DIM      = 3;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_LSB  = 2;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam int SQ_W         = 2 * SUM_W - 1;
    localparam int SCALE_SH     = 10;
    localparam int RAD_W        = SQ_W + 1 + SCALE_SH;
    localparam int SQRT_STEPS   = RAD_W / 2;
    localparam int REM_W        = 17;
    localparam int ROUND_ADD    = 9;
    localparam int STEP_CNT_W   = 4;

    // divide by 18 as a halving then a multiply by ceil(2^19 / 9)
    localparam int HALF_W       = REM_W - 1;
    localparam int RECIP_M      = 58255;
    localparam int RECIP_W      = 16;
    localparam int RECIP_SH     = 19;
    localparam int PROD_W       = HALF_W + RECIP_W;
    localparam int QUOT_W       = PROD_W - RECIP_SH;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
    } cfg_t;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_CALC = 2'b10
    } front_state_t;

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_MUL  = 7'b0000010,
        B_INIT = 7'b0000100,
        B_SQRT = 7'b0001000,
        B_RND  = 7'b0010000,
        B_DIV  = 7'b0100000,
        B_DONE = 7'b1000000
    } back_state_t;

endpackage

// ===== src/sgm_ram.sv =====
`timescale 1ns / 1ps
// sgm_ram: generic single write port, single read port ram with registered read
// no dependencies

module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sgm_front.sv =====
`timescale 1ns / 1ps
// sgm_front: pixel intake, raster position, line stores, 3x3 window and raw sums
// depends on sgm_pkg and sgm_ram

module sgm_front import sgm_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ENTRY_W = 1 + 2 * SUM_W + COL_W + ROW_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIX_W-1:0]   pixel_value,
    input  logic               start_of_frame,
    input  logic               q_full,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_data
);

    localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int CS_W  = SUM_W + 1;

    front_state_t state_reg, state_next;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [PIX_W-1:0] px_reg, px_next;
    logic [PIX_W-1:0] win_reg [6];
    logic [PIX_W-1:0] win_next [6];

    logic [CMP_W-1:0] fw_ext;
    logic [CMP_W-1:0] width_eff;
    logic [COL_W:0]   w;
    logic [ROW_W-1:0] h;
    logic             accept;
    logic [ROW_W-1:0] r0;
    logic [COL_W-1:0] c0;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic [2*PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0] top_px, mid_px;
    logic signed [CS_W-1:0] sx, sy;
    logic             interior;
    logic             last;

    // effective frame size
    assign fw_ext = CMP_W'(cfg.frame_width);

    always_comb
    begin
        if (fw_ext < CMP_W'(MIN_DIM))
        begin
            width_eff = CMP_W'(MIN_DIM);
        end
        else if (fw_ext > CMP_W'(MAX_WIDTH))
        begin
            width_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = fw_ext;
        end
    end

    assign w = width_eff[COL_W:0];
    assign h = (cfg.frame_height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : cfg.frame_height;

    assign accept   = in_valid && (state_reg == F_IDLE) && !q_full;
    assign in_stall = (state_reg != F_IDLE) || q_full;

    // position of the incoming pixel
    always_comb
    begin
        r0 = start_of_frame ? '0 : row_reg;
        c0 = start_of_frame ? '0 : col_reg;
        if ({1'b0, c0} >= w)
        begin
            c0 = '0;
        end
        if (r0 >= h)
        begin
            r0 = '0;
        end
    end

    sgm_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (state_reg == F_CALC),
        .waddr (cur_col_reg),
        .wdata ({mid_px, px_reg}),
        .re    (accept),
        .raddr (c0),
        .rdata (ram_rdata)
    );

    assign top_px = ram_rdata[2*PIX_W-1:PIX_W];
    assign mid_px = ram_rdata[PIX_W-1:0];

    // window order: left top/mid/bot, centre top/mid/bot
    always_comb
    begin
        sx = (CS_W'(signed'({1'b0, top_px})) - CS_W'(signed'({1'b0, win_reg[0]})))
           + ((CS_W'(signed'({1'b0, mid_px})) - CS_W'(signed'({1'b0, win_reg[1]}))) <<< 1)
           + (CS_W'(signed'({1'b0, px_reg})) - CS_W'(signed'({1'b0, win_reg[2]})));
        sy = (CS_W'(signed'({1'b0, win_reg[0]})) + (CS_W'(signed'({1'b0, win_reg[3]})) <<< 1)
              + CS_W'(signed'({1'b0, top_px})))
           - (CS_W'(signed'({1'b0, win_reg[2]})) + (CS_W'(signed'({1'b0, win_reg[5]})) <<< 1)
              + CS_W'(signed'({1'b0, px_reg})));
    end

    assign interior = (cur_row_reg >= ROW_W'(2)) && (cur_col_reg >= COL_W'(2));
    assign last     = (cur_row_reg == h - ROW_W'(1)) && ({1'b0, cur_col_reg} == w - (COL_W+1)'(1));

    assign q_push = (state_reg == F_CALC) && interior;
    assign q_data = {last, sy[SUM_W-1:0], sx[SUM_W-1:0],
                     cur_col_reg - COL_W'(1), cur_row_reg - ROW_W'(1)};

    assign col_inc = {1'b0, cur_col_reg} + (COL_W+1)'(1);
    assign row_inc = {1'b0, cur_row_reg} + (ROW_W+1)'(1);

    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        px_next      = px_reg;
        for (int i = 0; i < 6; i++)
        begin
            win_next[i] = win_reg[i];
        end
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    cur_row_next = r0;
                    cur_col_next = c0;
                    px_next      = pixel_value;
                    state_next   = F_CALC;
                end
            end
            F_CALC:
            begin
                win_next[0] = win_reg[3];
                win_next[1] = win_reg[4];
                win_next[2] = win_reg[5];
                win_next[3] = top_px;
                win_next[4] = mid_px;
                win_next[5] = px_reg;
                if (col_inc >= w)
                begin
                    col_next = '0;
                    if (row_inc >= {1'b0, h})
                    begin
                        row_next = '0;
                    end
                    else
                    begin
                        row_next = row_inc[ROW_W-1:0];
                    end
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                    row_next = cur_row_reg;
                end
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg <= cur_row_next;
        cur_col_reg <= cur_col_next;
        px_reg      <= px_next;
    end

endmodule

// ===== src/sgm_queue.sv =====
`timescale 1ns / 1ps
// sgm_queue: small register fifo between the front and back parts
// no dependencies

module sgm_queue #(
    parameter int DATA_W = 47,
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              full,
    output logic              empty
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/sgm_back.sv =====
`timescale 1ns / 1ps
// sgm_back: squares, square root and rounding divide to the q.4 magnitude
// depends on sgm_pkg

module sgm_back import sgm_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ENTRY_W = 1 + 2 * SUM_W + COL_W + ROW_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    output logic                     q_pop,
    input  logic [ENTRY_W-1:0]       q_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [ROW_W-1:0]         out_row,
    output logic [COL_W-1:0]         out_col,
    output logic signed [SUM_W-1:0]  grad_x_sum,
    output logic signed [SUM_W-1:0]  grad_y_sum,
    output logic [MAG_W-1:0]         grad_magnitude,
    output logic                     last_of_frame
);

    localparam int COL_LSB = ROW_W;
    localparam int SX_LSB  = ROW_W + COL_W;
    localparam int SY_LSB  = SX_LSB + SUM_W;

    back_state_t state_reg, state_next;

    logic [ENTRY_W-1:0]    ent_reg, ent_next;
    logic [SQ_W-1:0]       sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [RAD_W-1:0]      v_reg, v_next, res_reg, res_next, bit_reg, bit_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [MAG_W-1:0]      q_reg, q_next;

    logic                  out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [SUM_W-1:0]      out_sx_reg, out_sx_next, out_sy_reg, out_sy_next;
    logic [MAG_W-1:0]      out_mag_reg, out_mag_next;
    logic                  out_last_reg, out_last_next;

    logic signed [SUM_W-1:0]   ent_sx, ent_sy;
    logic signed [2*SUM_W-1:0] prod_x, prod_y;
    logic [SQ_W:0]             sq_sum;
    logic [RAD_W-1:0]          trial;
    logic [PROD_W-1:0]         recip_prod;
    logic [QUOT_W-1:0]         quot;

    assign ent_sx = ent_reg[SX_LSB +: SUM_W];
    assign ent_sy = ent_reg[SY_LSB +: SUM_W];
    assign prod_x = ent_sx * ent_sx;
    assign prod_y = ent_sy * ent_sy;
    assign sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign trial  = res_reg + bit_reg;

    assign recip_prod = PROD_W'(rem_reg[REM_W-1:1]) * PROD_W'(RECIP_M);
    assign quot       = recip_prod[PROD_W-1:RECIP_SH];

    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        v_next         = v_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        q_pop          = 1'b0;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_sx_next    = out_sx_reg;
        out_sy_next    = out_sy_reg;
        out_mag_next   = out_mag_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    ent_next   = q_data;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                sqx_next   = prod_x[SQ_W-1:0];
                sqy_next   = prod_y[SQ_W-1:0];
                state_next = B_INIT;
            end
            B_INIT:
            begin
                v_next     = {sq_sum, {SCALE_SH{1'b0}}};
                res_next   = '0;
                bit_next   = RAD_W'(1) << (RAD_W - 2);
                cnt_next   = STEP_CNT_W'(SQRT_STEPS - 1);
                state_next = B_SQRT;
            end
            B_SQRT:
            begin
                if (v_reg >= trial)
                begin
                    v_next   = v_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - STEP_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = B_RND;
                end
            end
            B_RND:
            begin
                rem_next   = REM_W'(res_reg) + REM_W'(ROUND_ADD);
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (quot > QUOT_W'(MAG_MAX))
                begin
                    q_next = MAG_W'(MAG_MAX);
                end
                else
                begin
                    q_next = quot[MAG_W-1:0];
                end
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_row_next   = ent_reg[ROW_W-1:0];
                    out_col_next   = ent_reg[COL_LSB +: COL_W];
                    out_sx_next    = ent_sx;
                    out_sy_next    = ent_sy;
                    out_mag_next   = q_reg;
                    out_last_next  = ent_reg[ENTRY_W-1];
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        v_reg        <= v_next;
        res_reg      <= res_next;
        bit_reg      <= bit_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_sx_reg   <= out_sx_next;
        out_sy_reg   <= out_sy_next;
        out_mag_reg  <= out_mag_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_row        = out_row_reg;
    assign out_col        = out_col_reg;
    assign grad_x_sum     = out_sx_reg;
    assign grad_y_sum     = out_sy_reg;
    assign grad_magnitude = out_mag_reg;
    assign last_of_frame  = out_last_reg;

endmodule

// ===== src/sobel_gradient_magnitude_top.sv =====
`timescale 1ns / 1ps
// sobel_gradient_magnitude_top: apb registers, front, queue and back of the block
// depends on sgm_pkg, sgm_front, sgm_queue, sgm_back

// Streaming 3x3 Sobel gradient magnitude over 8-bit grey pixels in raster order.
// Each result is for an interior pixel (row and column not on the frame border) and
// carries the raw x and y sums and round(16*hypot(x,y)/9) in unsigned q.4. The front
// takes a pixel, reads the line store ram, then writes it back and updates the window
// before it takes the next one; it also stalls while the queue is full. Interior
// pixels then go through a queue of QUEUE_DEPTH entries into the back unit, which
// works on one result at a time: it takes the entry, forms the squares, sets up the
// root, runs the bit-pair square root, adds the rounding term, does the divide by 18
// as a reciprocal multiply and hands off, held by any output stall. Frame width
// (register 0, address 0) and height (register 1, address 4) reset to 640 and 480
// and are clamped to 3..MAX_WIDTH and 3..4095 when used.

module sobel_gradient_magnitude_top import sgm_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    parameter int QUEUE_DEPTH = 4,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [PIX_W-1:0]        pixel_value,
    input  logic                    start_of_frame,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [ROW_W-1:0]        out_row,
    output logic [COL_W-1:0]        out_col,
    output logic signed [SUM_W-1:0] grad_x_sum,
    output logic signed [SUM_W-1:0] grad_y_sum,
    output logic [MAG_W-1:0]        grad_magnitude,
    output logic                    last_of_frame
);

    localparam int ENTRY_W = 1 + 2 * SUM_W + COL_W + ROW_W;

    cfg_t               cfg_reg, cfg_next;
    logic               reg_idx;
    logic               cfg_wr;
    logic               q_push, q_pop, q_full, q_empty;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_LSB];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_FRAME_WIDTH:  cfg_next.frame_width  = pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = pwdata[CFG_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg_reg.frame_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= CFG_W'(RESET_WIDTH);
            cfg_reg.frame_height <= CFG_W'(RESET_HEIGHT);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sgm_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel_value    (pixel_value),
        .start_of_frame (start_of_frame),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_wdata)
    );

    sgm_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    sgm_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .q_data         (q_rdata),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_row        (out_row),
        .out_col        (out_col),
        .grad_x_sum     (grad_x_sum),
        .grad_y_sum     (grad_y_sum),
        .grad_magnitude (grad_magnitude),
        .last_of_frame  (last_of_frame)
    );

endmodule

// ===== src/sgm_checker.sv =====
`timescale 1ns / 1ps
// sgm_checker: port-level assertions for the sobel gradient magnitude block
// depends on sgm_pkg; bound to sobel_gradient_magnitude_top

module sgm_checker import sgm_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    psel,
    input logic                    penable,
    input logic                    pwrite,
    input logic [APB_ADDR_W-1:0]   paddr,
    input logic [APB_DATA_W-1:0]   pwdata,
    input logic [APB_DATA_W-1:0]   prdata,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [ROW_W-1:0]        out_row,
    input logic [COL_W-1:0]        out_col,
    input logic signed [SUM_W-1:0] grad_x_sum,
    input logic signed [SUM_W-1:0] grad_y_sum,
    input logic [MAG_W-1:0]        grad_magnitude,
    input logic                    last_of_frame
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_col)
            && $stable(grad_x_sum) && $stable(grad_y_sum) && $stable(grad_magnitude)
            && $stable(last_of_frame))
        else $error("result changed while stalled");

    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_row != '0) && (out_col != '0))
        else $error("result for a border pixel");

    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (grad_x_sum == '0) && (grad_y_sum == '0) |-> grad_magnitude == '0)
        else $error("nonzero magnitude for flat window");

    a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[REG_IDX_LSB] == REG_FRAME_WIDTH)
            && $past(psel && penable && pwrite && (paddr[REG_IDX_LSB] == REG_FRAME_WIDTH))
            |-> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))
        else $error("frame width readback mismatch");

endmodule

bind sobel_gradient_magnitude_top sgm_checker #(
    .MAX_WIDTH (MAX_WIDTH)
) u_sgm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_col        (out_col),
    .grad_x_sum     (grad_x_sum),
    .grad_y_sum     (grad_y_sum),
    .grad_magnitude (grad_magnitude),
    .last_of_frame  (last_of_frame)
);
